[hdl/tsb_pkg.sv]
// Shared types, codes and defaults for the timer slot bank.
`default_nettype none

package tsb_pkg;

    localparam int SLOT_COUNT_DEF      = 8;
    localparam int TICKS_PER_MILLI_DEF = 10;
    localparam int COUNT_BITS_DEF      = 32;

    localparam int KIND_W         = 4;
    localparam int SLOT_W         = 3;
    localparam int AMOUNT_W       = 32;
    localparam int STATUS_W       = 3;
    localparam int PERIOD_MILLI_W = 29;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT_MS     = 4'd0,
        KIND_INIT_TICKS  = 4'd1,
        KIND_ONCE_MS     = 4'd2,
        KIND_ONCE_TICKS  = 4'd3,
        KIND_TICK        = 4'd4,
        KIND_START       = 4'd5,
        KIND_STOP        = 4'd6,
        KIND_SET_PERIOD  = 4'd7,
        KIND_READ_PERIOD = 4'd8
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NO_HANDLE = 3'd2,
        STAT_ZERO      = 3'd3,
        STAT_BIG       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                handle_valid;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] amount;
    } tsb_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [SLOT_W-1:0]         slot_out;
        logic                      handle_valid_out;
        logic                      expired;
        logic [PERIOD_MILLI_W-1:0] period_milli;
    } tsb_rsp_t;

endpackage

`default_nettype wire

[hdl/tsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tsb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/tsb_div.sv]
// Divider by a constant: reciprocal multiplication, quotient valid in the cycle after start.
`default_nettype none

module tsb_div #(
    parameter int WIDTH   = 32,
    parameter int DIVISOR = 10
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    output logic                  done,
    output logic      [WIDTH-1:0] quotient
);

    // x / d == (x * m) >> (WIDTH + SH) for every WIDTH-bit x,
    // with SH = ceil(log2 d) and m = floor(2^(WIDTH + SH) / d) + 1
    localparam int SH = $clog2(DIVISOR);
    localparam int PW = 2 * WIDTH + SH;
    localparam longint unsigned RECIP_L =
        ((64'd1 << (WIDTH + SH)) / 64'(DIVISOR)) + 64'd1;
    localparam logic [WIDTH:0] RECIP_K = (WIDTH + 1)'(RECIP_L);

    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic             done_reg, done_next;
    logic [PW-1:0]    prod;

    always_comb begin
        dvd_next  = dvd_reg;
        done_next = start;
        if (start) begin
            dvd_next = dividend;
        end
    end

    assign prod = PW'(dvd_reg) * PW'(RECIP_K);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
    end

    assign done     = done_reg;
    assign quotient = prod[WIDTH+SH +: WIDTH];

endmodule

`default_nettype wire

[hdl/timer_slot_bank.sv]
// Timer slot bank top level: request decode, slot sequencer and result register.
// Each request word yields exactly one result word. Most requests go from
// acceptance to a valid result through decode with the slot's RAM read,
// evaluate and write back, and a load of the result register. An init
// without a usable handle searches for the lowest free slot one slot per
// cycle. A read-period request divides the period by TICKS_PER_MILLI through
// a reciprocal multiplication in an extra divide state. The input is not
// ready while a request is in flight; a finished result waits in the output
// register without blocking the next request. Slot flags live in flip-flops;
// periods and counters share one RAM word per slot, and a per-slot written
// bit makes an unwritten slot read as zero, so no clearing pass follows reset.
`default_nettype none

module timer_slot_bank
    import tsb_pkg::*;
#(
    parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
    parameter int TICKS_PER_MILLI = TICKS_PER_MILLI_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tsb_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tsb_rsp_t      m_data
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WIDE_W = IDX_W + SLOT_W;
    localparam int PROD_W = AMOUNT_W + $clog2(TICKS_PER_MILLI + 1);
    localparam int CB     = COUNT_BITS;
    localparam logic [PROD_W-1:0] TPM_K      = PROD_W'(TICKS_PER_MILLI);
    localparam logic [WIDE_W-1:0] SLOTS_K    = WIDE_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0]  LAST_IDX_K = IDX_W'(SLOT_COUNT - 1);

    state_t                  state_reg, state_next;
    tsb_req_t                req_reg, req_next;
    logic [PROD_W-1:0]       ticks_reg, ticks_next;
    tsb_rsp_t                res_reg, res_next;
    logic [IDX_W-1:0]        scan_reg, scan_next;
    logic [SLOT_COUNT-1:0]   used_reg, used_next;
    logic [SLOT_COUNT-1:0]   en_reg, en_next;
    logic [SLOT_COUNT-1:0]   once_reg, once_next;
    logic [SLOT_COUNT-1:0]   written_reg, written_next;
    logic                    m_valid_reg, m_valid_next;
    tsb_rsp_t                m_data_reg, m_data_next;

    logic                    accept;
    logic                    ms_kind;
    logic [WIDE_W-1:0]       in_slot_wide, req_slot_wide, load_wide;
    logic [IDX_W-1:0]        in_idx, req_idx, load_idx;
    logic                    usable, amount_zero, too_big;
    logic [CB-1:0]           ticks_cb;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [2*CB-1:0]         ram_wdata, ram_rdata;
    logic [CB-1:0]           rd_period, rd_count, cnt_dec;
    logic                    load_en;
    logic                    div_start, div_done;
    logic [CB-1:0]           div_q;
    logic [31:0]             div_q_wide;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    assign ms_kind = (s_data.kind == KIND_INIT_MS) || (s_data.kind == KIND_ONCE_MS)
                  || (s_data.kind == KIND_SET_PERIOD);

    assign in_slot_wide  = WIDE_W'(s_data.slot);
    assign in_idx        = in_slot_wide[IDX_W-1:0];
    assign req_slot_wide = WIDE_W'(req_reg.slot);
    assign req_idx       = req_slot_wide[IDX_W-1:0];
    assign usable        = req_reg.handle_valid && (req_slot_wide < SLOTS_K);
    assign amount_zero   = (req_reg.amount == '0);
    assign too_big       = |ticks_reg[PROD_W-1:CB];
    assign ticks_cb      = ticks_reg[CB-1:0];

    // an unwritten slot reads as zero period and zero count
    assign rd_period = written_reg[req_idx] ? ram_rdata[2*CB-1:CB] : '0;
    assign rd_count  = written_reg[req_idx] ? ram_rdata[CB-1:0] : '0;
    assign cnt_dec   = (rd_count != '0) ? rd_count - CB'(1) : '0;

    assign load_wide  = WIDE_W'(load_idx);
    assign div_q_wide = 32'(div_q);

    tsb_ram #(
        .WIDTH(2 * CB),
        .DEPTH(SLOT_COUNT)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(in_idx),
        .rdata(ram_rdata)
    );

    tsb_div #(
        .WIDTH  (CB),
        .DIVISOR(TICKS_PER_MILLI)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(rd_period),
        .done    (div_done),
        .quotient(div_q)
    );

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        ticks_next   = ticks_reg;
        res_next     = res_reg;
        scan_next    = scan_reg;
        used_next    = used_reg;
        en_next      = en_reg;
        once_next    = once_reg;
        written_next = written_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = req_idx;
        ram_wdata    = {rd_period, rd_count};
        load_en      = 1'b0;
        load_idx     = req_idx;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next   = s_data;
                    ticks_next = ms_kind ? PROD_W'(s_data.amount) * TPM_K
                                         : PROD_W'(s_data.amount);
                    res_next.status           = STAT_OK;
                    res_next.slot_out         = s_data.slot;
                    res_next.handle_valid_out = s_data.handle_valid;
                    res_next.expired          = 1'b0;
                    res_next.period_milli     = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_DONE;
                case (req_reg.kind)
                    KIND_INIT_MS, KIND_INIT_TICKS, KIND_ONCE_MS, KIND_ONCE_TICKS: begin
                        if (amount_zero) begin
                            res_next.status = STAT_ZERO;
                        end else if (too_big) begin
                            res_next.status = STAT_BIG;
                        end else if (usable) begin
                            load_en = 1'b1;
                        end else begin
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    KIND_TICK, KIND_START, KIND_STOP, KIND_SET_PERIOD,
                    KIND_READ_PERIOD: begin
                        if (!usable) begin
                            res_next.status = STAT_NO_HANDLE;
                        end else if (req_reg.kind == KIND_TICK) begin
                            if (en_reg[req_idx]) begin
                                ram_we                = 1'b1;
                                written_next[req_idx] = 1'b1;
                                if (cnt_dec == '0) begin
                                    res_next.expired = 1'b1;
                                    if (once_reg[req_idx]) begin
                                        en_next[req_idx] = 1'b0;
                                        ram_wdata        = {rd_period, cnt_dec};
                                    end else begin
                                        ram_wdata = {rd_period, rd_period};
                                    end
                                end else begin
                                    ram_wdata = {rd_period, cnt_dec};
                                end
                            end
                        end else if (req_reg.kind == KIND_START) begin
                            ram_we                = 1'b1;
                            ram_wdata             = {rd_period, rd_period};
                            written_next[req_idx] = 1'b1;
                            en_next[req_idx]      = 1'b1;
                        end else if (req_reg.kind == KIND_STOP) begin
                            en_next[req_idx] = 1'b0;
                        end else if (req_reg.kind == KIND_SET_PERIOD) begin
                            if (amount_zero) begin
                                res_next.status = STAT_ZERO;
                            end else if (too_big) begin
                                res_next.status = STAT_BIG;
                            end else begin
                                ram_we                = 1'b1;
                                ram_wdata             = {ticks_cb, ticks_cb};
                                written_next[req_idx] = 1'b1;
                            end
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // walk the slots from the lowest until a free one turns up or the last slot is reached
                if (!used_reg[scan_reg]) begin
                    used_next[scan_reg] = 1'b1;
                    load_en             = 1'b1;
                    load_idx            = scan_reg;
                    state_next          = S_DONE;
                end else if (scan_reg == LAST_IDX_K) begin
                    res_next.status = STAT_FULL;
                    state_next      = S_DONE;
                end else begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    res_next.period_milli = div_q_wide[PERIOD_MILLI_W-1:0];
                    state_next            = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // load a fresh period into the chosen slot and enable it
        if (load_en) begin
            ram_we                     = 1'b1;
            ram_waddr                  = load_idx;
            ram_wdata                  = {ticks_cb, ticks_cb};
            written_next[load_idx]     = 1'b1;
            en_next[load_idx]          = 1'b1;
            once_next[load_idx]        = req_reg.kind[1];
            res_next.slot_out          = load_wide[SLOT_W-1:0];
            res_next.handle_valid_out  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            en_reg      <= '0;
            once_reg    <= '0;
            written_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            en_reg      <= en_next;
            once_reg    <= once_next;
            written_reg <= written_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        ticks_reg  <= ticks_next;
        res_reg    <= res_next;
        scan_reg   <= scan_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accepting a word");

    a_enabled_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (en_reg & ~written_reg) == '0)
        else $error("enabled slot has no written period");

    a_expired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.expired |-> m_data.status == STAT_OK)
        else $error("expiry reported with an error status");

    a_period_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.period_milli != '0)
            |-> m_data.status == STAT_OK && !m_data.expired)
        else $error("period reported outside a read period result");
`endif

endmodule

`default_nettype wire
